@@ rtl/cosine_similarity_engine_defines.svh @@
// assertion macros for the cosine similarity engine
// no dependencies; included by modules that carry assertions
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define CSE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/cse_pkg.sv @@
// shared types and constants for the cosine similarity engine
// no dependencies
`default_nettype none

package cse_pkg;

    localparam int ELEM_BITS_DEF = 16;
    localparam int ACC_W         = 48;
    localparam int OUT_W         = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last;
    } cse_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] similarity;
        logic                    zero_norm;
    } cse_out_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
        logic                    zero_norm;
    } cse_entry_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W:0]   v
    );
        logic signed [ACC_W:0] s;
        s = $signed({acc[ACC_W-1], acc}) + v;
        if (s > $signed({1'b0, ACC_MAX}))
            return ACC_MAX;
        else if (s < $signed({1'b1, ACC_MIN}))
            return ACC_MIN;
        else
            return s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/cse_front.sv @@
// front end: takes element beats, forms products and saturating sums
// depends on cse_pkg
`default_nettype none

module cse_front #(
    parameter int ELEM_BITS = cse_pkg::ELEM_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cse_pkg::cse_in_t    in_data,
    input  wire logic                full,
    output logic                     push,
    output cse_pkg::cse_entry_t      push_entry
);
    import cse_pkg::*;

    localparam int PW = 2 * ELEM_BITS;

    logic signed [ELEM_BITS-1:0] ea;
    logic signed [ELEM_BITS-1:0] eb;
    logic signed [PW-1:0]        pab;
    logic signed [PW-1:0]        paa;
    logic signed [PW-1:0]        pbb;

    logic signed [PW-1:0]        pab_reg;
    logic signed [PW-1:0]        paa_reg;
    logic signed [PW-1:0]        pbb_reg;
    logic                        s1_last_reg;
    logic                        s1_valid_reg;

    logic signed [ACC_W-1:0]     dot_reg;
    logic signed [ACC_W-1:0]     na_reg;
    logic signed [ACC_W-1:0]     nb_reg;
    logic signed [ACC_W-1:0]     dot_next;
    logic signed [ACC_W-1:0]     na_next;
    logic signed [ACC_W-1:0]     nb_next;

    logic                        advance;
    logic                        accept;

    assign ea  = $signed(ELEM_BITS'($unsigned(in_data.elem_a)));
    assign eb  = $signed(ELEM_BITS'($unsigned(in_data.elem_b)));
    assign pab = ea * eb;
    assign paa = ea * ea;
    assign pbb = eb * eb;

    assign advance  = s1_valid_reg && !(s1_last_reg && full);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign dot_next = sat_add(dot_reg, (ACC_W+1)'(pab_reg));
    assign na_next  = sat_add(na_reg, (ACC_W+1)'(paa_reg));
    assign nb_next  = sat_add(nb_reg, (ACC_W+1)'(pbb_reg));

    assign push                 = advance && s1_last_reg;
    assign push_entry.dot       = dot_next;
    assign push_entry.norm_a    = $unsigned(na_next);
    assign push_entry.norm_b    = $unsigned(nb_next);
    assign push_entry.zero_norm = (na_next == '0) || (nb_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            pab_reg      <= '0;
            paa_reg      <= '0;
            pbb_reg      <= '0;
            dot_reg      <= '0;
            na_reg       <= '0;
            nb_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= in_data.last;
                pab_reg      <= pab;
                paa_reg      <= paa;
                pbb_reg      <= pbb;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (s1_last_reg)
                begin
                    dot_reg <= '0;
                    na_reg  <= '0;
                    nb_reg  <= '0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    na_reg  <= na_next;
                    nb_reg  <= nb_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/cse_fifo.sv @@
// short queue of finished sums between front and back end
// depends on cse_pkg
`default_nettype none

module cse_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire cse_pkg::cse_entry_t   push_entry,
    input  wire logic                  pop,
    output cse_pkg::cse_entry_t        pop_entry,
    output logic                       full,
    output logic                       empty
);
    import cse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cse_entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cse_back.sv @@
// back end: products of the sums over a shared 32x24 multiplier, then a
// bit-by-bit search for the similarity magnitude; depends on cse_pkg
`default_nettype none
`include "cosine_similarity_engine_defines.svh"

module cse_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  empty,
    output logic                       pop,
    input  wire cse_pkg::cse_entry_t   entry,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output cse_pkg::cse_out_t          out_data
);
    import cse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_QSQ,
        S_CMP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        J_P,
        J_D,
        J_T
    } job_t;

    state_t          state_reg;
    job_t            job_reg;
    logic [1:0]      k_reg;
    logic [55:0]     prod_reg;
    logic [127:0]    acc_reg;
    logic [47:0]     na_reg;
    logic [47:0]     nb_reg;
    logic [47:0]     dabs_reg;
    logic            neg_reg;
    logic [95:0]     p_reg;
    logic [95:0]     d_reg;
    logic [31:0]     q2_reg;
    logic [15:0]     m_reg;
    logic [3:0]      bit_reg;
    logic            out_valid_reg;
    cse_out_t        out_reg;

    logic [31:0]     x_op;
    logic [23:0]     y_op;
    logic [6:0]      shift_amt;
    logic [127:0]    acc_sum;
    logic [15:0]     trial;
    logic [16:0]     q17;
    logic [31:0]     q_sq;
    logic            pass;
    logic [15:0]     m_new;
    logic            done;
    logic [47:0]     dabs;
    logic [15:0]     sim;

    always_comb
    begin
        unique case (job_reg)
            J_P:
            begin
                x_op      = {8'b0, k_reg[0] ? na_reg[47:24] : na_reg[23:0]};
                y_op      = k_reg[1] ? nb_reg[47:24] : nb_reg[23:0];
                shift_amt = 7'(24 * (32'(k_reg[0]) + 32'(k_reg[1])));
            end
            J_D:
            begin
                x_op      = {8'b0, k_reg[0] ? dabs_reg[47:24] : dabs_reg[23:0]};
                y_op      = k_reg[1] ? dabs_reg[47:24] : dabs_reg[23:0];
                shift_amt = 7'(24 * (32'(k_reg[0]) + 32'(k_reg[1])));
            end
            J_T:
            begin
                x_op      = q2_reg;
                y_op      = p_reg[24*k_reg +: 24];
                shift_amt = 7'(24 * 32'(k_reg));
            end
            default:
            begin
                x_op      = '0;
                y_op      = '0;
                shift_amt = '0;
            end
        endcase
    end

    assign acc_sum = acc_reg + (128'(prod_reg) << shift_amt);
    assign trial   = m_reg | (16'd1 << bit_reg);
    assign q17     = {trial, 1'b0} - 17'd1;
    assign q_sq    = q17[15:0] * q17[15:0];
    assign pass    = (acc_reg <= {d_reg, 32'b0});
    assign m_new   = pass ? trial : m_reg;
    assign done    = (bit_reg == 4'd0) || (pass && (bit_reg == 4'd15));
    assign dabs    = entry.dot[47] ? 48'(-entry.dot) : $unsigned(entry.dot);
    assign sim     = neg_reg ? 16'(-m_new) : (m_new[15] ? 16'h7FFF : m_new);

    assign pop       = (state_reg == S_IDLE) && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= J_P;
            k_reg         <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            dabs_reg      <= '0;
            neg_reg       <= 1'b0;
            p_reg         <= '0;
            d_reg         <= '0;
            q2_reg        <= '0;
            m_reg         <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        na_reg   <= entry.norm_a;
                        nb_reg   <= entry.norm_b;
                        dabs_reg <= dabs;
                        neg_reg  <= entry.dot[47];
                        if (entry.zero_norm)
                        begin
                            out_reg.similarity <= '0;
                            out_reg.zero_norm  <= 1'b1;
                            out_valid_reg      <= 1'b1;
                            state_reg          <= S_OUT;
                        end
                        else
                        begin
                            job_reg   <= J_P;
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= x_op * y_op;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    acc_reg <= acc_sum;
                    if (k_reg == 2'd3)
                    begin
                        unique case (job_reg)
                            J_P:
                            begin
                                p_reg     <= acc_sum[95:0];
                                job_reg   <= J_D;
                                k_reg     <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_MUL;
                            end
                            J_D:
                            begin
                                d_reg     <= acc_sum[95:0];
                                m_reg     <= '0;
                                bit_reg   <= 4'd15;
                                state_reg <= S_QSQ;
                            end
                            default:
                            begin
                                state_reg <= S_CMP;
                            end
                        endcase
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_QSQ:
                begin
                    q2_reg    <= q_sq;
                    job_reg   <= J_T;
                    k_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_CMP:
                begin
                    m_reg <= m_new;
                    if (done)
                    begin
                        out_reg.similarity <= $signed(sim);
                        out_reg.zero_norm  <= 1'b0;
                        out_valid_reg      <= 1'b1;
                        state_reg          <= S_OUT;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= S_QSQ;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CSE_ASSERT_IMPL(a_zero_norm_zero_sim, clk, rst_n, out_valid_reg && out_reg.zero_norm, out_reg.similarity == 16'sd0, "zero norm with nonzero similarity")
    `CSE_ASSERT_ALWAYS(a_mag_range, clk, rst_n, m_reg <= 16'h8000, "magnitude above one")
    `CSE_ASSERT_IMPL(a_pos_sign, clk, rst_n, out_valid_reg && !out_reg.zero_norm && !neg_reg, !out_reg.similarity[15], "negative result for positive dot")

endmodule

`default_nettype wire

@@ rtl/cosine_similarity_engine.sv @@
// top level of the cosine similarity engine
// depends on cse_pkg, cse_front, cse_fifo, cse_back
`default_nettype none

// One element pair is taken per cycle; the front end multiplies it and adds it to
// three saturating 48-bit sums in a two-stage pipeline. On the last beat of a vector
// the sums go into a two-entry queue, so the next vector streams in while the back
// end works. The back end uses one 32x24 multiplier sequentially: it takes
// the entry, forms the norm product and the squared dot, then runs up to sixteen
// trials of the bit-by-bit magnitude search and holds the result beat until it is
// taken. A magnitude of one ends the search at its first trial, and a zero norm
// goes straight to the result beat. The input stalls on a last beat while the queue
// is full.
module cosine_similarity_engine #(
    parameter int ELEM_BITS = cse_pkg::ELEM_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cse_pkg::cse_in_t    in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cse_pkg::cse_out_t        out_data
);
    import cse_pkg::*;

    logic        full;
    logic        empty;
    logic        push;
    logic        pop;
    cse_entry_t  push_entry;
    cse_entry_t  pop_entry;

    cse_front #(
        .ELEM_BITS(ELEM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    cse_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (full),
        .empty      (empty)
    );

    cse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .entry     (pop_entry),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ bench/cse_checker.sv @@
`timescale 1ns / 100ps
// checker for the cosine similarity engine: predicts each vector result and compares it
// against the output beats; depends on cse_pkg
module cse_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  cse_pkg::cse_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  cse_pkg::cse_out_t out_data,
    output int                errors,
    output int                pending,
    output int                results_seen,
    output int                zero_seen,
    output int                extreme_seen
);
    import cse_pkg::*;

    localparam logic signed [48:0] SUM_HI = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SUM_LO = -49'sh0_8000_0000_0000;

    logic signed [47:0] dot_acc;
    logic signed [47:0] na_acc;
    logic signed [47:0] nb_acc;
    cse_out_t           sim_queue[$];

    function automatic logic signed [47:0] clamp_add(logic signed [47:0] acc,
                                                     logic signed [31:0] v);
        logic signed [48:0] s;
        s = acc + v;
        if (s > SUM_HI)
            return SUM_HI[47:0];
        if (s < SUM_LO)
            return SUM_LO[47:0];
        return s[47:0];
    endfunction

    function automatic logic signed [15:0] cosine_of(logic signed [47:0] dot,
                                                     logic [47:0] na, logic [47:0] nb);
        logic [129:0] nprod;
        logic [129:0] rhs;
        logic [129:0] trial;
        logic [47:0]  dabs;
        logic [17:0]  lo;
        logic [17:0]  hi;
        logic [17:0]  mid;
        logic [33:0]  q;
        dabs  = dot[47] ? -dot : dot;
        nprod = {82'b0, na} * {82'b0, nb};
        rhs   = ({82'b0, dabs} * {82'b0, dabs}) << 32;
        lo    = 0;
        hi    = 18'd32768;
        while (lo < hi)
        begin
            mid   = (lo + hi + 1) >> 1;
            q     = 2 * mid - 1;
            trial = {96'b0, q} * {96'b0, q} * nprod;
            if (trial <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot[47])
            return -lo[15:0];
        if (lo > 18'd32767)
            lo = 18'd32767;
        return lo[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [47:0] d;
        logic signed [47:0] a2;
        logic signed [47:0] b2;
        cse_out_t           want;
        cse_out_t           got;
        if (!rst_n)
        begin
            dot_acc      <= '0;
            na_acc       <= '0;
            nb_acc       <= '0;
            errors       <= 0;
            pending      <= 0;
            results_seen <= 0;
            zero_seen    <= 0;
            extreme_seen <= 0;
            sim_queue.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                d  = clamp_add(dot_acc, in_data.elem_a * in_data.elem_b);
                a2 = clamp_add(na_acc, in_data.elem_a * in_data.elem_a);
                b2 = clamp_add(nb_acc, in_data.elem_b * in_data.elem_b);
                if (in_data.last)
                begin
                    want.zero_norm  = (a2 == 0) || (b2 == 0);
                    want.similarity = want.zero_norm ? '0 : cosine_of(d, a2, b2);
                    sim_queue.insert(sim_queue.size(), want);
                    dot_acc <= '0;
                    na_acc  <= '0;
                    nb_acc  <= '0;
                end
                else
                begin
                    dot_acc <= d;
                    na_acc  <= a2;
                    nb_acc  <= b2;
                end
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                results_seen <= results_seen + 1;
                if (got.zero_norm)
                    zero_seen <= zero_seen + 1;
                if (got.similarity == 16'sh7FFF || got.similarity == -16'sh8000)
                    extreme_seen <= extreme_seen + 1;
                if (sim_queue.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat with nothing expected: sim %0d zn %0b",
                                 $time, got.similarity, got.zero_norm);
                    errors <= errors + 1;
                end
                else
                begin
                    want = sim_queue.pop_front();
                    if (got.similarity !== want.similarity || got.zero_norm !== want.zero_norm)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch: sim exp %0d got %0d, zn exp %0b got %0b",
                                     $time, want.similarity, got.similarity,
                                     want.zero_norm, got.zero_norm);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= sim_queue.size();
        end
    end

endmodule

@@ bench/tb_cosine_similarity_engine.sv @@
`timescale 1ns / 100ps
// top of the cosine similarity engine bench: clock, reset, stimulus and verdict
// depends on cse_pkg, cosine_similarity_engine and cse_checker
module tb_cosine_similarity_engine;
    import cse_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 900;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    cse_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    cse_out_t out_data;

    int       errors;
    int       pending;
    int       results_seen;
    int       zero_seen;
    int       extreme_seen;
    int       beats_sent = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;
    logic     hold_req = 1'b0;
    int       hold_left = 0;
    int       rx_mode = 0;
    int       rx_left = 0;

    always #6 clk = ~clk;

    cosine_similarity_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    cse_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .errors(errors), .pending(pending), .results_seen(results_seen),
        .zero_seen(zero_seen), .extreme_seen(extreme_seen)
    );

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(10, 120);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a beat", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_beat(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic lst, input bit no_gaps);
        cse_in_t beat;
        beat.elem_a = a;
        beat.elem_b = b;
        beat.last   = lst;
        in_data  <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
            end
            else
                burst_left--;
        end
    endtask

    function automatic logic signed [15:0] rand_elem(input int kind);
        case (kind)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(0, 31))) - 16'sd16;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            default: return '0;
        endcase
    endfunction

    initial
    begin
        int               len;
        int               kind;
        int               rel;
        logic signed [15:0] a;
        logic signed [15:0] b;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed corners
        send_beat(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        send_beat(-16'sh8000, -16'sh8000, 1'b1, 1'b0);
        send_beat(16'sh7FFF, -16'sh8000, 1'b1, 1'b0);
        send_beat(-16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        send_beat(16'sh0000, 16'sh0005, 1'b1, 1'b0);
        send_beat(16'sh0003, 16'sh0000, 1'b1, 1'b0);
        send_beat(16'sh0000, 16'sh0000, 1'b1, 1'b0);
        send_beat(16'sh0001, 16'sh0000, 1'b0, 1'b0);
        send_beat(16'sh0000, 16'sh0001, 1'b1, 1'b0);
        send_beat(16'sh0001, 16'sh0001, 1'b0, 1'b0);
        send_beat(16'sh0001, -16'sh0001, 1'b1, 1'b0);
        send_beat(16'sh0003, 16'sh0004, 1'b0, 1'b0);
        send_beat(16'sh0004, 16'sh0003, 1'b1, 1'b0);
        send_beat(-16'sh0001, 16'sh0001, 1'b1, 1'b0);
        send_beat(16'sh5555, -16'sh2AAB, 1'b0, 1'b0);
        send_beat(-16'sh5556, 16'sh2AAA, 1'b1, 1'b0);

        // short vectors while the receiver holds off, so the input stalls
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int v = 0; v < 20; v++)
            send_beat(rand_elem(0), rand_elem(0), 1'b1, 1'b1);

        while (beats_sent < 1700)
        begin
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 8);
            kind = $urandom_range(0, 9);
            rel  = $urandom_range(0, 4);
            for (int i = 0; i < len; i++)
            begin
                a = rand_elem(kind < 5 ? 0 : kind < 7 ? 1 : kind < 8 ? 2 : 3);
                case (rel)
                    0: b = a;
                    1: b = -a;
                    2: b = a + $signed(16'($urandom_range(0, 63))) - 16'sd32;
                    default: b = rand_elem(kind == 9 ? 3 : $urandom_range(0, 2));
                endcase
                send_beat(a, b, i == len - 1, 1'b0);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("%0d beats in, %0d results (%0d zero norm, %0d at full scale)",
                 beats_sent, results_seen, zero_seen, extreme_seen);
        $display("covered zero norms, full-scale corners, receiver hold-off and random stalls");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
